### design/kd_tree_knn_k_distance_macros.svh
// Assertion macros for the kd-tree k-distance block.
// Used by the top level; the clock is clk and the reset is arst_n.
`ifndef KD_TREE_KNN_K_DISTANCE_MACROS_SVH
`define KD_TREE_KNN_K_DISTANCE_MACROS_SVH

// Condition implies consequence in the same cycle.
`define KDK_ASSERT_IMP(lbl, cond, conseq, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

// Condition implies consequence in the next cycle.
`define KDK_ASSERT_NXT(lbl, cond, conseq, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

### design/kdk_pkg.sv
// Shared constants, codes and controller/datapath interface types.
// No dependencies; used by kdk_ctrl, kdk_path and the top level of the kd-tree k-distance block.
package kdk_pkg;

	localparam int DEF_MAX_POINTS = 1024;
	localparam int DEF_MAX_K = 16;
	localparam int DEF_MAX_DIMS = 4;
	localparam int DEF_COORD_BITS = 16;

	localparam int POS_W = 10;
	localparam int COORD_IN_W = 16;
	localparam int DIST_OUT_W = 18;
	localparam int OP_W = 2;
	localparam int CFG_W = 11;
	localparam int CFG_IDX_W = 2;
	localparam int IN_TDATA_W = 88;
	localparam int OUT_TDATA_W = 32;

	localparam logic [OP_W-1:0] OP_LOAD_POINT = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_SLOT = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE = 2'd2;

	typedef struct packed {
		logic wr_point;
		logic wr_slot;
		logic tgt_read;
		logic query_init;
		logic top_read;
		logic node_read;
		logic dist_step;
		logic insert;
		logic pop_step;
		logic sqrt_start;
		logic out_load;
	} kdk_cmd_t;

	typedef struct packed {
		logic stack_empty;
		logic top_phase;
		logic dist_done;
		logic sqrt_done;
	} kdk_sts_t;

endpackage

### design/kdk_isqrt.sv
// Iterative floor square root, two radicand bits per cycle.
// Depends on nothing; instantiated by the datapath.
module kdk_isqrt #(
	parameter int W = 34,
	localparam int RW = W / 2 + 2,
	localparam int NIT = W / 2,
	localparam int NCW = $clog2(NIT + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   value,
	output logic [W/2-1:0] root,
	output logic           done
);

	logic [W-1:0]   rad_q;
	logic [RW-1:0]  rem_q;
	logic [W/2-1:0] root_q;
	logic [NCW-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [RW-1:0]  rem2;
	logic [RW-1:0]  trial;

	assign rem2 = {rem_q[RW-3:0], rad_q[W-1 -: 2]};
	assign trial = {root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == NCW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= NCW'(NIT);
			end else if (busy_q) begin
				cnt_q <= cnt_q - NCW'(1);
				if (cnt_q == NCW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= value;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[W-3:0], 2'b00};
			if (rem2 >= trial) begin
				rem_q <= rem2 - trial;
				root_q <= {root_q[W/2-2:0], 1'b1};
			end else begin
				rem_q <= rem2;
				root_q <= {root_q[W/2-2:0], 1'b0};
			end
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

### design/kdk_ctrl.sv
// Query sequencer: intake, tree walk steps, square root and result hand-off.
// Depends on kdk_pkg; drives the datapath through kdk_cmd_t.
module kdk_ctrl
	import kdk_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [OP_W-1:0] in_op,
	output logic            in_ready,
	input  logic            out_free,
	input  kdk_sts_t        sts,
	output kdk_cmd_t        cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_TGT = 4'd1;
	localparam logic [3:0] ST_POP = 4'd2;
	localparam logic [3:0] ST_NODE = 4'd3;
	localparam logic [3:0] ST_DIST = 4'd4;
	localparam logic [3:0] ST_INS = 4'd5;
	localparam logic [3:0] ST_SQRT = 4'd6;
	localparam logic [3:0] ST_OUT = 4'd7;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.wr_point = (in_op == OP_LOAD_POINT);
					cmd.wr_slot = (in_op == OP_LOAD_SLOT);
					if (in_op == OP_QUERY) begin
						cmd.tgt_read = 1'b1;
						state_d = ST_TGT;
					end
				end
			end
			ST_TGT: begin
				cmd.query_init = 1'b1;
				state_d = ST_POP;
			end
			ST_POP: begin
				if (sts.stack_empty) begin
					cmd.sqrt_start = 1'b1;
					state_d = ST_SQRT;
				end else if (!sts.top_phase) begin
					cmd.top_read = 1'b1;
					state_d = ST_NODE;
				end else begin
					cmd.pop_step = 1'b1;
				end
			end
			ST_NODE: begin
				cmd.node_read = 1'b1;
				state_d = ST_DIST;
			end
			ST_DIST: begin
				cmd.dist_step = 1'b1;
				if (sts.dist_done) begin
					state_d = ST_INS;
				end
			end
			ST_INS: begin
				cmd.insert = 1'b1;
				state_d = ST_POP;
			end
			ST_SQRT: begin
				if (sts.sqrt_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### design/kdk_path.sv
// Datapath: point and slot memories, walk stack, distance unit, k-best list.
// Depends on kdk_pkg and kdk_isqrt; commanded by kdk_ctrl.
module kdk_path
	import kdk_pkg::*;
#(
	parameter int MAX_POINTS = DEF_MAX_POINTS,
	parameter int MAX_K = DEF_MAX_K,
	parameter int MAX_DIMS = DEF_MAX_DIMS,
	parameter int COORD_BITS = DEF_COORD_BITS,
	localparam int NW = $clog2(MAX_POINTS + 1),
	localparam int KW = $clog2(MAX_K + 1),
	localparam int CW = $clog2(MAX_DIMS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  kdk_cmd_t              cmd,
	output kdk_sts_t              sts,
	input  logic [POS_W-1:0]      position,
	input  logic [POS_W-1:0]      slot_point,
	input  logic [COORD_IN_W-1:0] coord_zero,
	input  logic [COORD_IN_W-1:0] coord_one,
	input  logic [COORD_IN_W-1:0] coord_two,
	input  logic [COORD_IN_W-1:0] coord_three,
	input  logic [NW-1:0]         n_cfg,
	input  logic [KW-1:0]         k_cfg,
	input  logic [CW-1:0]         dims_cfg,
	output logic [POS_W-1:0]      query_point,
	output logic [DIST_OUT_W-1:0] k_distance,
	output logic                  heap_filled
);

	localparam int CB = COORD_BITS;
	localparam int AW = $clog2(MAX_POINTS);
	localparam int DIMW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int ROW_W = MAX_DIMS * CB;
	localparam int SQW = 2 * CB;
	localparam int DW = SQW + $clog2(MAX_DIMS);
	localparam int SW = DW + (DW % 2);
	localparam int SD = AW + 1;
	localparam int TW = $clog2(SD + 1);
	localparam int SIW = $clog2(SD);
	localparam int RCP_SH = 20;
	localparam int RCP = (1 << RCP_SH) / MAX_POINTS;

	function automatic logic [AW-1:0] wrap_idx(input logic [POS_W-1:0] v);
		logic [31:0] q;
		logic [31:0] r;
		begin
			q = (32'(v) * 32'(RCP)) >> RCP_SH;
			r = 32'(v) - q * 32'(MAX_POINTS);
			if (r >= 32'(MAX_POINTS)) begin
				r = r - 32'(MAX_POINTS);
			end
			if (MAX_POINTS >= (1 << POS_W)) begin
				r = 32'(v);
			end
			return AW'(r);
		end
	endfunction

	logic [ROW_W-1:0] pmem [MAX_POINTS];
	logic [AW-1:0]    tmem [MAX_POINTS];
	logic [ROW_W-1:0] prow_q;
	logic [AW-1:0]    node_q;
	logic [ROW_W-1:0] tgt_q;
	logic [AW-1:0]    qpos_q;
	logic [AW-1:0]    mid_q;

	logic [COORD_IN_W-1:0] cin [4];
	logic [ROW_W-1:0]      in_row;
	logic [AW-1:0]         pos_w;
	logic [AW-1:0]         prd_addr;

	logic [AW-1:0]   st_lo [SD];
	logic [AW-1:0]   st_hi [SD];
	logic [DIMW-1:0] st_ax [SD];
	logic            st_ph [SD];
	logic            st_fe [SD];
	logic [SQW-1:0]  st_sq [SD];
	logic [TW-1:0]   top_q;
	logic [SIW-1:0]  tp;
	logic [SIW-1:0]  tpush;
	logic            can_push;

	logic [AW-1:0]   t_lo;
	logic [AW-1:0]   t_hi;
	logic [DIMW-1:0] t_ax;
	logic            t_ph;
	logic            t_fe;
	logic [SQW-1:0]  t_sq;
	logic [AW:0]     span;
	logic [AW-1:0]   mid;
	logic [CW:0]     axp1;
	logic [DIMW-1:0] ax_nxt;

	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   cnt_s1;
	logic            v_s1;
	logic [SQW-1:0]  sq_s1;
	logic [DW-1:0]   acc_q;
	logic [SQW-1:0]  axsq_q;
	logic [DIMW-1:0] ci;
	logic [CB-1:0]   ca;
	logic [CB-1:0]   cbv;
	logic [CB:0]     df;
	logic [CB:0]     ad;
	logic [2*CB+1:0] prod;

	logic [CB-1:0]   ax_t;
	logic [CB-1:0]   ax_n;
	logic            near_left;
	logic            left_empty;
	logic            right_empty;
	logic [AW-1:0]   near_lo;
	logic [AW-1:0]   near_hi;
	logic            near_empty;
	logic [AW-1:0]   far_lo;
	logic [AW-1:0]   far_hi;
	logic            far_empty;

	logic [DW-1:0] hp [MAX_K];
	logic [DW-1:0] hp_up [MAX_K];
	logic          gt [MAX_K];
	logic          gp [MAX_K];
	logic          gt2 [MAX_K];
	logic          gp2 [MAX_K];
	logic [KW-1:0] fill_q;
	logic          short;
	logic          go;

	logic [SW/2-1:0] root;
	logic            sqrt_done;

	assign cin[0] = coord_zero;
	assign cin[1] = coord_one;
	assign cin[2] = coord_two;
	assign cin[3] = coord_three;

	always_comb begin
		for (int d = 0; d < MAX_DIMS; d++) begin
			if (d < 4) begin
				in_row[d*CB +: CB] = CB'($signed(cin[d % 4]));
			end else begin
				in_row[d*CB +: CB] = '0;
			end
		end
	end

	assign pos_w = wrap_idx(position);
	assign prd_addr = cmd.tgt_read ? pos_w : node_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_point) begin
			pmem[pos_w] <= in_row;
		end
		if (cmd.tgt_read || cmd.node_read) begin
			prow_q <= pmem[prd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_slot) begin
			tmem[pos_w] <= wrap_idx(slot_point);
		end
		if (cmd.top_read) begin
			node_q <= tmem[mid];
		end
	end

	// Top-of-stack frame and the node split of its slot range.
	assign tp = SIW'(top_q - TW'(1));
	assign tpush = SIW'(top_q);
	assign can_push = (top_q < TW'(SD));
	assign t_lo = st_lo[tp];
	assign t_hi = st_hi[tp];
	assign t_ax = st_ax[tp];
	assign t_ph = st_ph[tp];
	assign t_fe = st_fe[tp];
	assign t_sq = st_sq[tp];
	assign span = {1'b0, t_hi} - {1'b0, t_lo} + (AW+1)'(1);
	assign mid = t_lo + AW'(span >> 1);
	assign axp1 = (CW+1)'(t_ax) + (CW+1)'(1);
	assign ax_nxt = (axp1 >= (CW+1)'(dims_cfg)) ? '0 : DIMW'(axp1);

	// Distance unit: one coordinate per cycle, product registered.
	assign ci = DIMW'(cnt_q);
	assign ca = tgt_q[ci*CB +: CB];
	assign cbv = prow_q[ci*CB +: CB];
	assign df = {ca[CB-1], ca} - {cbv[CB-1], cbv};
	assign ad = df[CB] ? ((CB+1)'(0) - df) : df;
	assign prod = (2*CB+2)'(ad) * (2*CB+2)'(ad);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			v_s1 <= 1'b0;
		end else if (cmd.node_read) begin
			cnt_q <= '0;
			v_s1 <= 1'b0;
		end else if (cmd.dist_step) begin
			if (cnt_q < dims_cfg) begin
				cnt_q <= cnt_q + CW'(1);
				v_s1 <= 1'b1;
			end else begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.node_read) begin
			acc_q <= '0;
		end else if (cmd.dist_step) begin
			sq_s1 <= SQW'(prod);
			cnt_s1 <= cnt_q;
			if (v_s1) begin
				acc_q <= acc_q + DW'(sq_s1);
				if (cnt_s1 == CW'(t_ax)) begin
					axsq_q <= sq_s1;
				end
			end
		end
	end

	// Child ranges around the node; the near side is the target's side.
	assign ax_t = tgt_q[t_ax*CB +: CB];
	assign ax_n = prow_q[t_ax*CB +: CB];
	assign near_left = ($signed(ax_t) <= $signed(ax_n));
	assign left_empty = (mid_q == t_lo);
	assign right_empty = (mid_q == t_hi);
	assign near_lo = near_left ? t_lo : mid_q + AW'(1);
	assign near_hi = near_left ? mid_q - AW'(1) : t_hi;
	assign near_empty = near_left ? left_empty : right_empty;
	assign far_lo = near_left ? mid_q + AW'(1) : t_lo;
	assign far_hi = near_left ? t_hi : mid_q - AW'(1);
	assign far_empty = near_left ? right_empty : left_empty;

	assign short = (fill_q < k_cfg);
	assign go = short || (DW'(t_sq) < hp[0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
		end else if (cmd.query_init) begin
			top_q <= (n_cfg != '0) ? TW'(1) : '0;
		end else if (cmd.insert) begin
			if (!near_empty && can_push) begin
				top_q <= top_q + TW'(1);
			end
		end else if (cmd.pop_step) begin
			if (!(go && !t_fe)) begin
				top_q <= top_q - TW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.query_init) begin
			st_lo[0] <= '0;
			st_hi[0] <= AW'(n_cfg - NW'(1));
			st_ax[0] <= '0;
			st_ph[0] <= 1'b0;
			st_fe[0] <= 1'b0;
		end else if (cmd.insert) begin
			st_lo[tp] <= far_lo;
			st_hi[tp] <= far_hi;
			st_fe[tp] <= far_empty;
			st_ph[tp] <= 1'b1;
			st_sq[tp] <= axsq_q;
			if (!near_empty && can_push) begin
				st_lo[tpush] <= near_lo;
				st_hi[tpush] <= near_hi;
				st_ax[tpush] <= ax_nxt;
				st_ph[tpush] <= 1'b0;
				st_fe[tpush] <= 1'b0;
			end
		end else if (cmd.pop_step) begin
			if (go && !t_fe) begin
				st_ph[tp] <= 1'b0;
				st_ax[tp] <= ax_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tgt_read) begin
			qpos_q <= pos_w;
		end
		if (cmd.query_init) begin
			tgt_q <= prow_q;
		end
		if (cmd.top_read) begin
			mid_q <= mid;
		end
	end

	// k best distances as a list sorted largest first; entry 0 is the bound.
	always_comb begin
		for (int i = 0; i < MAX_K; i++) begin
			hp_up[i] = '0;
			if (i + 1 < MAX_K) begin
				hp_up[i] = hp[i + 1];
			end
			gt[i] = (i < int'(fill_q)) && (hp[i] > acc_q);
			gt2[i] = (i + 1 < int'(fill_q)) && (hp_up[i] > acc_q);
		end
		for (int i = 0; i < MAX_K; i++) begin
			gp[i] = 1'b1;
			gp2[i] = 1'b1;
			if (i > 0) begin
				gp[i] = gt[i - 1];
				gp2[i] = gt2[i - 1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			for (int i = 0; i < MAX_K; i++) begin
				if (short) begin
					if (!gt[i]) begin
						hp[i] <= gp[i] ? acc_q : hp[(i > 0) ? i - 1 : 0];
					end
				end else if (acc_q < hp[0]) begin
					if (gt2[i]) begin
						hp[i] <= hp_up[i];
					end else if (gp2[i]) begin
						hp[i] <= acc_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.query_init) begin
			fill_q <= '0;
		end else if (cmd.insert && short) begin
			fill_q <= fill_q + KW'(1);
		end
	end

	kdk_isqrt #(
		.W(SW)
	) u_isqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.sqrt_start),
		.value (heap_filled ? SW'(hp[0]) : '0),
		.root  (root),
		.done  (sqrt_done)
	);

	assign sts = '{
		stack_empty: (top_q == '0),
		top_phase: t_ph,
		dist_done: (cnt_q == dims_cfg) && !v_s1,
		sqrt_done: sqrt_done
	};

	assign heap_filled = (fill_q == k_cfg);
	assign k_distance = DIST_OUT_W'(root);
	assign query_point = POS_W'(qpos_q);

endmodule

### design/kd_tree_knn_k_distance.sv
// Top level of the kd-tree k-nearest-neighbor distance engine.
// Depends on kdk_pkg, kdk_ctrl, kdk_path and the assertion macro header.
//
//   Channel   Group              Payload (lowest bit first)
//   input     s_tvalid/s_tready  s_tuser: op; s_tdata: position, slot_point, coords
//   output    m_tvalid/m_tready  m_tuser: heap_filled; m_tdata: query_point, k_distance
//   config    cfg_we             cfg_index, cfg_data
//
// Point and slot loads are written on acceptance and leave intake open. A query's walk
// is paced by the single point memory read port and the one-coordinate-per-cycle
// distance multiplier, its tail by the square root unit. Reset clears the controller,
// stack pointer, list fill and output valid; memories are not cleared. A stalled result
// holds m_tvalid and its data; intake reopens once the result is loaded into the
// output register.
`include "kd_tree_knn_k_distance_macros.svh"

module kd_tree_knn_k_distance
	import kdk_pkg::*;
#(
	parameter int MAX_POINTS = DEF_MAX_POINTS,
	parameter int MAX_K = DEF_MAX_K,
	parameter int MAX_DIMS = DEF_MAX_DIMS,
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// position, slot_point, coord_zero, coord_one, coord_two, coord_three, zero pad
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// op
	input  logic [OP_W-1:0]        s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// query_point, k_distance, zero pad
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// heap_filled
	output logic                   m_tuser,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	localparam int NW = $clog2(MAX_POINTS + 1);
	localparam int KW = $clog2(MAX_K + 1);
	localparam int CW = $clog2(MAX_DIMS + 1);

	logic [NW-1:0] n_q;
	logic [KW-1:0] k_q;
	logic [CW-1:0] dims_q;
	logic [4:0]    k_raw;
	logic [2:0]    d_raw;

	kdk_cmd_t cmd;
	kdk_sts_t sts;

	logic                  m_tvalid_q;
	logic [POS_W-1:0]      qp_q;
	logic [DIST_OUT_W-1:0] kd_q;
	logic                  hf_q;
	logic [POS_W-1:0]      qp;
	logic [DIST_OUT_W-1:0] kd;
	logic                  hf;

	assign k_raw = cfg_data[4:0];
	assign d_raw = cfg_data[2:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
			k_q <= KW'(1);
			dims_q <= CW'((MAX_DIMS < 2) ? MAX_DIMS : 2);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POINT_COUNT: begin
					n_q <= (32'(cfg_data) > 32'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(cfg_data);
				end
				REG_NEIGHBOR_COUNT: begin
					if (k_raw == '0) begin
						k_q <= KW'(1);
					end else if (32'(k_raw) > 32'(MAX_K)) begin
						k_q <= KW'(MAX_K);
					end else begin
						k_q <= KW'(k_raw);
					end
				end
				REG_DIMS_IN_USE: begin
					if (d_raw == '0) begin
						dims_q <= CW'(1);
					end else if (32'(d_raw) > 32'(MAX_DIMS)) begin
						dims_q <= CW'(MAX_DIMS);
					end else begin
						dims_q <= CW'(d_raw);
					end
				end
				default: begin
				end
			endcase
		end
	end

	kdk_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_op   (s_tuser),
		.in_ready(s_tready),
		.out_free(!m_tvalid_q || m_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	kdk_path #(
		.MAX_POINTS(MAX_POINTS),
		.MAX_K     (MAX_K),
		.MAX_DIMS  (MAX_DIMS),
		.COORD_BITS(COORD_BITS)
	) u_path (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.position   (s_tdata[9:0]),
		.slot_point (s_tdata[19:10]),
		.coord_zero (s_tdata[35:20]),
		.coord_one  (s_tdata[51:36]),
		.coord_two  (s_tdata[67:52]),
		.coord_three(s_tdata[83:68]),
		.n_cfg      (n_q),
		.k_cfg      (k_q),
		.dims_cfg   (dims_q),
		.query_point(qp),
		.k_distance (kd),
		.heap_filled(hf)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			qp_q <= qp;
			kd_q <= hf ? kd : '0;
			hf_q <= hf;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {(OUT_TDATA_W - POS_W - DIST_OUT_W)'(0), kd_q, qp_q};
	assign m_tuser = hf_q;

	`KDK_ASSERT_IMP(a_out_free, cmd.out_load, !m_tvalid_q || m_tready, "result overwritten")
	`KDK_ASSERT_IMP(a_out_busy, cmd.out_load, !s_tready, "intake open while delivering")
	`KDK_ASSERT_NXT(a_query_busy, s_tvalid && s_tready && (s_tuser == OP_QUERY), !s_tready, "intake open during a query")

endmodule
